>>> rtl/core/vlcp_pkg.sv
// Shared constants, codes and types of the variable-length code packer.
// Used by vlcp_packer and variable_length_code_packer_top; no dependencies.
package vlcp_pkg;

   localparam int NUM_SYMBOLS  = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int COUNT_WIDTH  = 24;

   localparam int OP_W     = 2;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_IN_W = 6;
   localparam int BYTE_W   = 8;
   localparam int TOTAL_W  = 24;

   localparam int ADDR_W  = $clog2(NUM_SYMBOLS);
   localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int ENTRY_W = CODE_W + LEN_W;
   localparam int NEED_W  = 4;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PACK,
      ST_FLUSH,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic encode;
      logic finish;
      logic append_term;
   } cmd_type;

endpackage

>>> rtl/core/variable_length_code_packer_top.sv
// Top level of the variable-length code packer: request decode, code table RAM,
// mode register and packer. Depends on vlcp_pkg, vlcp_ram and vlcp_packer.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    op, symbol, code_word, code_length
//   rsp_      out         rsp_valid/rsp_ready    out_byte, end_of_stream, total_bytes
//   csr_      in          csr_wr_en              csr_wr_data (append_terminator)
//
// Load writes the table entry. Encode: a registered table lookup, then one emitted byte
// per cycle while the result register is free, and a last step to absorb leftover bits
// when fewer than a byte remain. Finish flushes pending bits, then sends the terminator
// byte when append_terminator is set. One item is in work at a time.
// Reset clears the FSM, accumulator and byte count and sets append_terminator;
// table contents stay undefined until loaded. A full result register with
// rsp_ready low holds the packer; the next beat is taken while a result waits.
module variable_length_code_packer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [vlcp_pkg::OP_W-1:0]        req_op,
   input  logic [vlcp_pkg::SYM_W-1:0]       req_symbol,
   input  logic [vlcp_pkg::CODE_W-1:0]      req_code_word,
   input  logic [vlcp_pkg::LEN_IN_W-1:0]    req_code_length,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [vlcp_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_end_of_stream,
   output logic [vlcp_pkg::TOTAL_W-1:0]     rsp_total_bytes,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data
);

   localparam int SYM_X_W = vlcp_pkg::SYM_W + vlcp_pkg::ADDR_W;
   localparam int LEN_X_W = vlcp_pkg::LEN_IN_W + vlcp_pkg::LEN_W;

   logic                             append_term_ff;
   logic                             idle;
   logic                             accept;
   logic [SYM_X_W-1:0]               sym_ext;
   logic                             in_range;
   logic [vlcp_pkg::ADDR_W-1:0]      addr;
   logic [LEN_X_W-1:0]               len_ext;
   logic [vlcp_pkg::LEN_W-1:0]       len_store;
   logic                             wr_en;
   logic                             rd_en;
   logic [vlcp_pkg::ENTRY_W-1:0]     wr_entry;
   logic [vlcp_pkg::ENTRY_W-1:0]     rd_entry;
   vlcp_pkg::cmd_type                cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         append_term_ff <= 1'b1;
      end else if (csr_wr_en) begin
         append_term_ff <= csr_wr_data;
      end
   end

   assign req_ready = idle;
   assign accept    = req_valid && idle;
   assign sym_ext   = SYM_X_W'(req_symbol);
   assign in_range  = sym_ext < SYM_X_W'(vlcp_pkg::NUM_SYMBOLS);
   assign addr      = sym_ext[vlcp_pkg::ADDR_W-1:0];
   assign len_ext   = LEN_X_W'(req_code_length);
   assign len_store = (len_ext > LEN_X_W'(vlcp_pkg::MAX_CODE_LEN))
                    ? vlcp_pkg::LEN_W'(vlcp_pkg::MAX_CODE_LEN)
                    : vlcp_pkg::LEN_W'(len_ext);
   assign wr_entry  = {len_store, req_code_word};
   assign wr_en     = accept && req_op == vlcp_pkg::OP_LOAD && in_range;
   assign rd_en     = accept && req_op == vlcp_pkg::OP_ENCODE && in_range;

   assign cmd.encode      = rd_en;
   assign cmd.finish      = accept && req_op == vlcp_pkg::OP_FINISH;
   assign cmd.append_term = append_term_ff;

   vlcp_ram #(
      .WIDTH (vlcp_pkg::ENTRY_W),
      .DEPTH (vlcp_pkg::NUM_SYMBOLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   vlcp_packer u_packer (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .ram_code          (rd_entry[vlcp_pkg::CODE_W-1:0]),
      .ram_len           (rd_entry[vlcp_pkg::ENTRY_W-1:vlcp_pkg::CODE_W]),
      .idle              (idle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_total_bytes   (rsp_total_bytes)
   );

endmodule

>>> rtl/core/vlcp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module vlcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/vlcp_packer.sv
// Bit packer: control FSM, byte accumulator, byte counter and result register.
// Depends on vlcp_pkg; takes table entries from the RAM read port.
module vlcp_packer (
   input  logic                            clock,
   input  logic                            reset,
   input  vlcp_pkg::cmd_type               cmd,
   input  logic [vlcp_pkg::CODE_W-1:0]     ram_code,
   input  logic [vlcp_pkg::LEN_W-1:0]      ram_len,
   output logic                            idle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vlcp_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_end_of_stream,
   output logic [vlcp_pkg::TOTAL_W-1:0]    rsp_total_bytes
);

   vlcp_pkg::state_type state_ff, state_in;

   logic [vlcp_pkg::BYTE_W-1:0]      acc_ff, acc_in;
   logic [2:0]                       pend_ff, pend_in;
   logic [vlcp_pkg::COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_inc;
   logic [vlcp_pkg::LEN_W-1:0]       klen_ff, klen_in;
   logic                             first_ff, first_in;
   logic                             rsp_valid_ff;
   logic [vlcp_pkg::BYTE_W-1:0]      byte_ff;
   logic                             eos_ff;
   logic [vlcp_pkg::TOTAL_W-1:0]     total_ff;

   logic                         out_free;
   logic [vlcp_pkg::LEN_W-1:0]   k_cur;
   logic [vlcp_pkg::NEED_W-1:0]  need;
   logic                         can_emit;
   logic [vlcp_pkg::LEN_W-1:0]   shift_amt;
   logic [vlcp_pkg::CODE_W-1:0]  frag;
   logic [vlcp_pkg::BYTE_W-1:0]  pack_byte;
   logic [2:0]                   k3;
   logic [vlcp_pkg::BYTE_W-1:0]  absorb_byte;
   logic [vlcp_pkg::BYTE_W-1:0]  flush_byte;

   logic                         load_out;
   logic [vlcp_pkg::BYTE_W-1:0]  out_byte;
   logic                         out_eos;
   logic                         clear_stream;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign k_cur     = first_ff ? ram_len : klen_ff;
   assign need      = vlcp_pkg::NEED_W'(4'd8 - {1'b0, pend_ff});
   assign can_emit  = k_cur >= need;
   assign shift_amt = vlcp_pkg::LEN_W'(k_cur - vlcp_pkg::LEN_W'(need));
   assign frag      = ram_code >> shift_amt;
   assign pack_byte = (acc_ff << need) | (frag[vlcp_pkg::BYTE_W-1:0] & (8'hFF >> pend_ff));
   assign k3        = 3'(k_cur);
   assign absorb_byte = (acc_ff << k3) | (ram_code[vlcp_pkg::BYTE_W-1:0] & ~(8'hFF << k3));
   assign flush_byte  = acc_ff << need;
   assign cnt_inc     = (cnt_ff == vlcp_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vlcp_pkg::ST_IDLE: begin
            if (cmd.encode) begin
               state_in = vlcp_pkg::ST_PACK;
            end else if (cmd.finish) begin
               state_in = vlcp_pkg::ST_FLUSH;
            end
         end
         vlcp_pkg::ST_PACK: begin
            if (!can_emit) begin
               state_in = vlcp_pkg::ST_IDLE;
            end else if (out_free && shift_amt == '0) begin
               state_in = vlcp_pkg::ST_IDLE;
            end
         end
         vlcp_pkg::ST_FLUSH: begin
            if (pend_ff == '0 || out_free) begin
               state_in = cmd.append_term ? vlcp_pkg::ST_TERM : vlcp_pkg::ST_IDLE;
            end
         end
         vlcp_pkg::ST_TERM: begin
            if (out_free) begin
               state_in = vlcp_pkg::ST_IDLE;
            end
         end
         default: state_in = vlcp_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      load_out     = 1'b0;
      out_byte     = '0;
      out_eos      = 1'b0;
      clear_stream = 1'b0;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      klen_in      = klen_ff;
      first_in     = first_ff;
      case (state_ff)
         vlcp_pkg::ST_IDLE: begin
            first_in = cmd.encode;
         end
         vlcp_pkg::ST_PACK: begin
            if (can_emit) begin
               if (out_free) begin
                  load_out = 1'b1;
                  out_byte = pack_byte;
                  acc_in   = '0;
                  pend_in  = '0;
                  klen_in  = shift_amt;
                  first_in = 1'b0;
               end
            end else begin
               acc_in   = absorb_byte;
               pend_in  = pend_ff + k3;
               first_in = 1'b0;
            end
         end
         vlcp_pkg::ST_FLUSH: begin
            if (pend_ff != '0) begin
               if (out_free) begin
                  load_out     = 1'b1;
                  out_byte     = flush_byte;
                  out_eos      = !cmd.append_term;
                  acc_in       = '0;
                  pend_in      = '0;
                  clear_stream = !cmd.append_term;
               end
            end else begin
               clear_stream = !cmd.append_term;
            end
         end
         vlcp_pkg::ST_TERM: begin
            if (out_free) begin
               load_out     = 1'b1;
               out_byte     = '0;
               out_eos      = 1'b1;
               clear_stream = 1'b1;
            end
         end
         default: begin
            first_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (clear_stream) begin
         cnt_in = '0;
      end else if (load_out) begin
         cnt_in = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vlcp_pkg::ST_IDLE;
         acc_ff       <= '0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      klen_ff <= klen_in;
      if (load_out) begin
         byte_ff  <= out_byte;
         eos_ff   <= out_eos;
         total_ff <= vlcp_pkg::TOTAL_W'(cnt_inc);
      end
   end

   assign idle              = state_ff == vlcp_pkg::ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_end_of_stream = eos_ff;
   assign rsp_total_bytes   = total_ff;

`ifndef SYNTH
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.encode && cmd.finish))
      else $error("encode and finish started together");

   a_cmd_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != vlcp_pkg::ST_IDLE) |-> !(cmd.encode || cmd.finish))
      else $error("command started while busy");

   a_finish_to_flush: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == vlcp_pkg::ST_FLUSH)
      else $error("finish did not enter flush");

   a_eos_clears_count: assert property (@(posedge clock) disable iff (reset)
      (load_out && out_eos) |=> cnt_ff == '0 && pend_ff == '0)
      else $error("stream not restarted after end beat");

   a_pack_has_bits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vlcp_pkg::ST_PACK && !first_ff) |-> klen_ff != '0)
      else $error("pack continued with no code bits left");
`endif

endmodule

>>> verif/variable_length_code_packer_top_test.sv
// Self-checking testbench for variable_length_code_packer_top: a directed table, then
// random load, encode, finish and unknown-op beats under several sender and receiver idling mixes.
// Depends on vlcp_pkg and the packer RTL; expected bytes are typed in or predicted in-bench.
module variable_length_code_packer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vlcp_pkg::*;

   localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
   localparam int IDLE_GAP   = 12;
   localparam int TIMEOUT_NS = 3_000_000;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   // A CSR row carries the mode in code[0]. Known rows carry the bytes typed in,
   // first byte in bits 31:24, with eos bit i for byte i.
   typedef struct packed {
      row_kind_type          kind;
      logic [OP_W-1:0]       op;
      logic [SYM_W-1:0]      sym;
      logic [CODE_W-1:0]     code;
      logic [LEN_IN_W-1:0]   len;
      logic                  known;
      logic [2:0]            n;
      logic [31:0]           bytes;
      logic [3:0]            eos;
      logic [TOTAL_W-1:0]    first_total;
   } plan_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic               last;
      logic [TOTAL_W-1:0] total;
   } out_beat_type;

   localparam int PLAN_LEN = 28;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ROW_BEAT, OP_FINISH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_0000, 4'b0001, 24'd1},
      '{ROW_BEAT, OP_LOAD,    8'h00, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF, 4'b0000, 24'd1},
      '{ROW_BEAT, OP_LOAD,    8'hFF, 32'h0000_0005, 6'd3,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_FINISH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd2, 32'hA000_0000, 4'b0010, 24'd5},
      '{ROW_BEAT, OP_LOAD,    8'h01, 32'hAAAA_AAAA, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_LOAD,    8'h02, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF, 4'b0000, 24'd1},
      '{ROW_BEAT, OP_LOAD,    8'h80, 32'hDEAD_BEEF, 6'd33, 1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_LOAD,    8'h04, 32'h0000_0015, 6'd5,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h04, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_FINISH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_CSR,  OP_LOAD,    8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_FINISH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_LOAD,    8'h10, 32'h0000_0003, 6'd2,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h10, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_FINISH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hC000_0000, 4'b0001, 24'd1},
      '{ROW_BEAT, OP_ENCODE,  8'h10, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h10, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h10, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_BEAT, OP_ENCODE,  8'h10, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hFF00_0000, 4'b0000, 24'd1},
      '{ROW_BEAT, OP_FINISH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000, 4'b0000, 24'd0},
      '{ROW_CSR,  OP_LOAD,    8'h00, 32'h0000_0001, 6'd0,  1'b0, 3'd0, 32'h0000_0000, 4'b0000, 24'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op = OP_LOAD;
   logic [SYM_W-1:0]     req_symbol = '0;
   logic [CODE_W-1:0]    req_code_word = '0;
   logic [LEN_IN_W-1:0]  req_code_length = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_end_of_stream;
   logic [TOTAL_W-1:0]   rsp_total_bytes;
   logic                 csr_wr_en = 1'b0;
   logic                 csr_wr_data = 1'b0;

   // Packer state as the testbench sees it.
   logic [CODE_W-1:0]      code_mem [NUM_SYMBOLS] = '{default: '0};
   logic [LEN_IN_W-1:0]    len_mem [NUM_SYMBOLS] = '{default: '0};
   bit                     stored [NUM_SYMBOLS] = '{default: 1'b0};
   logic [7:0]             acc = '0;
   int                     nbits = 0;
   logic [COUNT_WIDTH-1:0] byte_count = '0;
   logic                   term_mode = 1'b1;

   out_beat_type just_packed [$];
   out_beat_type owed [$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_left = 0;
   int          mismatches = 0;

   variable_length_code_packer_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_symbol        (req_symbol),
      .req_code_word     (req_code_word),
      .req_code_length   (req_code_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_total_bytes   (rsp_total_bytes),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void emit(input logic [7:0] value, input logic last);
      if (byte_count != COUNT_MAX) byte_count++;
      just_packed.push_back('{data: value, last: last, total: byte_count});
   endfunction

   function automatic void pack_code(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                     input logic [CODE_W-1:0] code,
                                     input logic [LEN_IN_W-1:0] len);
      logic [CODE_W-1:0] word;
      case (op)
         OP_LOAD: begin
            code_mem[sym] = code;
            len_mem[sym] = (len > MAX_CODE_LEN) ? LEN_IN_W'(MAX_CODE_LEN) : len;
            stored[sym] = 1'b1;
         end
         OP_ENCODE: begin
            word = code_mem[sym];
            for (int k = int'(len_mem[sym]) - 1; k >= 0; k--) begin
               acc = {acc[6:0], word[k]};
               nbits++;
               if (nbits == 8) begin
                  emit(acc, 1'b0);
                  acc = '0;
                  nbits = 0;
               end
            end
         end
         OP_FINISH: begin
            if (nbits != 0) emit(8'(acc << (8 - nbits)), !term_mode);
            if (term_mode) emit(8'h00, 1'b1);
            acc = '0;
            nbits = 0;
            byte_count = '0;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_IN_W-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_symbol <= sym;
      req_code_word <= code;
      req_code_length <= len;
      do @(posedge clock); while (req_ready !== 1'b1);
      just_packed.delete();
      pack_code(op, sym, code, len);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (owed.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic csr_write(input logic value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      term_mode = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_item(output bit counted);
      int unsigned pick;
      logic [SYM_W-1:0] sym;
      logic [LEN_IN_W-1:0] len;
      pick = $urandom_range(99);
      counted = 1'b1;
      if (pick < 18) begin
         sym = SYM_W'($urandom_range(255));
         case ($urandom_range(9))
            0: len = '0;
            1: len = LEN_IN_W'($urandom_range(63, 33));
            default: len = LEN_IN_W'($urandom_range(32, 1));
         endcase
         send_item(OP_LOAD, sym, $urandom, len);
      end else if (pick < 82) begin
         do sym = SYM_W'($urandom_range(255)); while (!stored[sym]);
         send_item(OP_ENCODE, sym, $urandom, LEN_IN_W'($urandom));
      end else if (pick < 94) begin
         send_item(OP_FINISH, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));
      end else begin
         send_item(OP_UNKNOWN, SYM_W'($urandom), $urandom, LEN_IN_W'($urandom));
         counted = 1'b0;
      end
      foreach (just_packed[i]) owed.push_back(just_packed[i]);
   endtask

   task automatic run_phase(input logic mode, input int unsigned idle, input int unsigned stall,
                            input int unsigned hold, input int count);
      int done;
      bit counted;
      csr_write(mode);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      hold_left = hold;
      done = 0;
      while (done < count) begin
         random_item(counted);
         if (counted) done++;
      end
   endtask

   initial begin
      out_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (owed.size() == 0) begin
               $display("%0t: unexpected beat, actual byte %h eos %b total %0d", $time,
                        rsp_out_byte, rsp_end_of_stream, rsp_total_bytes);
               mismatches++;
            end else begin
               want = owed.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte expected %h actual %h", $time, want.data,
                           rsp_out_byte);
                  mismatches++;
               end
               if (rsp_end_of_stream !== want.last) begin
                  $display("%0t: end_of_stream expected %b actual %b", $time, want.last,
                           rsp_end_of_stream);
                  mismatches++;
               end
               if (rsp_total_bytes !== want.total) begin
                  $display("%0t: total_bytes expected %0d actual %0d", $time, want.total,
                           rsp_total_bytes);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_LEN; r++) begin
         if (PLAN[r].kind == ROW_CSR) begin
            csr_write(PLAN[r].code[0]);
         end else begin
            send_item(PLAN[r].op, PLAN[r].sym, PLAN[r].code, PLAN[r].len);
            if (PLAN[r].known) begin
               for (int i = 0; i < PLAN[r].n; i++)
                  owed.push_back('{data: PLAN[r].bytes[31 - 8 * i -: 8],
                                   last: PLAN[r].eos[i],
                                   total: TOTAL_W'(PLAN[r].first_total + i)});
            end else begin
               foreach (just_packed[i]) owed.push_back(just_packed[i]);
            end
         end
      end

      run_phase(1'b0, 0, 0, 0, 50);
      run_phase(1'b1, 84, 0, 0, 50);
      // hold the receiver off so the packer backs up into the request side
      run_phase(1'b0, 0, 84, 300, 50);
      run_phase(1'b1, 32, 32, 0, 50);

      rsp_stall_pct = 0;
      wait_idle();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> variable_length_code_packer_top.f
rtl/core/vlcp_pkg.sv
rtl/core/vlcp_ram.sv
rtl/core/vlcp_packer.sv
rtl/core/variable_length_code_packer_top.sv
verif/variable_length_code_packer_top_test.sv
